// ----- hw/rtl/bpr_pkg.sv -----
// Shared constants, register codes and word types of the cross-batch pooling reducer.
`timescale 1ns / 1ps
package bpr_pkg;

	// Storage sizes
	localparam int MAX_SLICE   = 4096;
	localparam int MAX_BATCH   = 256;
	localparam int POS_W       = $clog2(MAX_SLICE);
	localparam int MEM_W       = $clog2(MAX_BATCH);
	localparam int TOT_W       = 40;
	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;
	localparam int MODE_W     = 2;
	localparam int BATCH_W    = 9;
	localparam int SLICE_W    = 13;
	localparam int INV_W      = 17;

	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BATCH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV   = 2'd3;

	// Pooling modes
	localparam logic [MODE_W-1:0] MODE_WSUM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MAX  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AVG  = 2'd2;

	// Settings the back end needs
	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [INV_W-1:0]  inverse;
	} bpr_cfg_t;

	// One classified word on its way from front to back
	typedef struct packed {
		logic signed [31:0] data;     // product in weighted mode, sample otherwise
		logic [POS_W-1:0]   pos;
		logic [MEM_W-1:0]   mem;
		logic               first;
		logic               last_row;
		logic               last_pos;
	} bpr_item_t;

	// Back end status
	typedef struct packed {
		logic en;
		logic s1_valid;
	} bpr_back_stat_t;

endpackage

// ----- hw/rtl/bpr_ram.sv -----
// Generic single-write, single-read RAM with registered read data (read-first).
`timescale 1ns / 1ps
module bpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/bpr_front.sv -----
// Front end: configuration registers, position and member counters, word classification.
`timescale 1ns / 1ps
module bpr_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [15:0]             sample_value,
	input  logic signed [15:0]             member_weight,
	input  logic                           q_space,
	output logic                           push,
	output bpr_pkg::bpr_item_t             item,
	output bpr_pkg::bpr_cfg_t              cfg
);
	import bpr_pkg::*;

	logic [MODE_W-1:0]  mode_q;
	logic [BATCH_W-1:0] batch_q;
	logic [SLICE_W-1:0] slice_q;
	logic [INV_W-1:0]   inv_q;
	logic [POS_W-1:0]   pos_q;
	logic [MEM_W-1:0]   mem_q;

	logic [BATCH_W-1:0] nb, nb_m1;
	logic [SLICE_W-1:0] ns, ns_m1;
	logic               last_row, last_pos;
	logic signed [31:0] prod;

	// Clamp batch and slice sizes to the supported range
	always_comb begin
		if (batch_q == '0) begin
			nb = BATCH_W'(1);
		end else if (batch_q > BATCH_W'(MAX_BATCH)) begin
			nb = BATCH_W'(MAX_BATCH);
		end else begin
			nb = batch_q;
		end
		if (slice_q == '0) begin
			ns = SLICE_W'(1);
		end else if (slice_q > SLICE_W'(MAX_SLICE)) begin
			ns = SLICE_W'(MAX_SLICE);
		end else begin
			ns = slice_q;
		end
		nb_m1 = nb - BATCH_W'(1);
		ns_m1 = ns - SLICE_W'(1);
	end

	assign last_row = (mem_q == nb_m1[MEM_W-1:0]);
	assign last_pos = (pos_q == ns_m1[POS_W-1:0]);
	assign prod     = 32'(sample_value) * 32'(member_weight);

	assign in_ready = q_space;
	assign push     = in_valid && q_space;

	// Classified word
	always_comb begin
		item.data     = (mode_q == MODE_WSUM) ? prod : 32'(sample_value);
		item.pos      = pos_q;
		item.mem      = mem_q;
		item.first    = (mem_q == '0);
		item.last_row = last_row;
		item.last_pos = last_pos;
	end

	assign cfg.mode    = mode_q;
	assign cfg.inverse = inv_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_MAX;
			batch_q <= BATCH_W'(1);
			slice_q <= SLICE_W'(1);
			inv_q   <= INV_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[MODE_W-1:0];
				REG_BATCH: batch_q <= cfg_data[BATCH_W-1:0];
				REG_SLICE: slice_q <= cfg_data[SLICE_W-1:0];
				REG_INV:   inv_q   <= cfg_data[INV_W-1:0];
				default:   mode_q  <= mode_q;
			endcase
		end
	end

	// Stream counters; any register write restarts at member 0, position 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			mem_q <= '0;
		end else if (cfg_we) begin
			pos_q <= '0;
			mem_q <= '0;
		end else if (push) begin
			if (last_pos) begin
				pos_q <= '0;
				mem_q <= last_row ? '0 : mem_q + MEM_W'(1);
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/bpr_queue.sv -----
// Short word queue between the front end and the back end.
`timescale 1ns / 1ps
module bpr_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  bpr_pkg::bpr_item_t          push_item,
	output logic                        space,
	output logic                        head_valid,
	output bpr_pkg::bpr_item_t          head_item,
	input  logic                        pop,
	output logic [bpr_pkg::QCNT_W-1:0]  count
);
	import bpr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	bpr_item_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign space      = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign count      = count_q;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/bpr_back.sv -----
// Back end: accumulator read-modify-write, scaling, rounding, saturation, output register.
`timescale 1ns / 1ps
module bpr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpr_pkg::bpr_cfg_t             cfg,
	input  logic                          item_valid,
	input  bpr_pkg::bpr_item_t            item,
	output logic                          item_take,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            pooled_value,
	output logic [bpr_pkg::MEM_W-1:0]     winner_index,
	output logic [bpr_pkg::POS_W-1:0]     slice_position,
	output logic                          last_result,
	output bpr_pkg::bpr_back_stat_t       stat
);
	import bpr_pkg::*;

	localparam int RAM_W = TOT_W + MEM_W;
	localparam int AVG_W = 58;
	localparam int RES_W = 42;

	logic en, pop;

	// Accumulator memory
	logic             ram_we;
	logic [POS_W-1:0] ram_raddr;
	logic [RAM_W-1:0] ram_wdata, ram_rdata;

	// Stage 1: word whose accumulator is being read and rewritten
	logic            s1_v_q;
	bpr_item_t       s1_item_q;

	// Last write, forwarded to the word right behind it
	logic                    fwd_v_q;
	logic [POS_W-1:0]        fwd_pos_q;
	logic signed [TOT_W-1:0] fwd_total_q;
	logic [MEM_W-1:0]        fwd_best_q;

	logic signed [TOT_W-1:0] old_total, new_total, add_val;
	logic [MEM_W-1:0]        old_best, new_best;
	logic signed [TOT_W:0]   sum_w;
	logic signed [TOT_W-1:0] sum_sat;
	logic                    fwd_hit;

	// Stage 2: updated total of a last-row word
	logic                    s2_v_q;
	logic signed [TOT_W-1:0] s2_total_q;
	logic [MEM_W-1:0]        s2_best_q;
	logic [POS_W-1:0]        s2_pos_q;
	logic                    s2_last_pos_q;

	logic signed [TOT_W:0]   wround;
	logic [36:0]             plo;
	logic signed [37:0]      phi;

	// Stage 3: rounded weighted sum, average partial products and max total
	logic                    s3_v_q;
	logic signed [26:0]      s3_w_q;
	logic [36:0]             s3_plo_q;
	logic signed [37:0]      s3_phi_q;
	logic signed [TOT_W-1:0] s3_max_q;
	logic [MEM_W-1:0]        s3_best_q;
	logic [POS_W-1:0]        s3_pos_q;
	logic                    s3_last_pos_q;

	logic signed [AVG_W-1:0] avg_full;
	logic signed [RES_W-1:0] res;
	logic signed [31:0]      res_sat;

	// Output register
	logic                    out_v_q;
	logic signed [31:0]      out_val_q;
	logic [MEM_W-1:0]        out_win_q;
	logic [POS_W-1:0]        out_pos_q;
	logic                    out_last_q;

	// Whole back end moves together unless a result word is held
	assign en        = !out_v_q || out_ready;
	assign pop       = item_valid && en;
	assign item_take = en;

	// While stalled, keep reading the held word's entry
	assign ram_raddr = en ? item.pos : s1_item_q.pos;
	assign ram_we    = s1_v_q && en && (cfg.mode == MODE_WSUM || cfg.mode == MODE_MAX ||
	                                    cfg.mode == MODE_AVG);
	assign ram_wdata = {new_best, new_total};

	bpr_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_SLICE)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (s1_item_q.pos),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Accumulator update
	always_comb begin
		fwd_hit   = fwd_v_q && (fwd_pos_q == s1_item_q.pos);
		old_total = fwd_hit ? fwd_total_q : $signed(ram_rdata[TOT_W-1:0]);
		old_best  = fwd_hit ? fwd_best_q : ram_rdata[TOT_W +: MEM_W];
		add_val   = TOT_W'(s1_item_q.data);
		sum_w     = (TOT_W+1)'(old_total) + (TOT_W+1)'(add_val);
		if (sum_w[TOT_W] != sum_w[TOT_W-1]) begin
			sum_sat = sum_w[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
		end else begin
			sum_sat = sum_w[TOT_W-1:0];
		end
		new_total = old_total;
		new_best  = old_best;
		case (cfg.mode)
			MODE_WSUM, MODE_AVG: begin
				new_total = s1_item_q.first ? add_val : sum_sat;
			end
			MODE_MAX: begin
				if (s1_item_q.first || (add_val > old_total)) begin
					new_total = add_val;
					new_best  = s1_item_q.mem;
				end
			end
			default: begin
				new_total = old_total;
			end
		endcase
	end

	// Scaling of the stage 2 total
	assign wround = (TOT_W+1)'(s2_total_q) + (TOT_W+1)'(8192);
	assign plo    = 37'(s2_total_q[19:0]) * 37'(cfg.inverse);
	assign phi    = 38'($signed(s2_total_q[TOT_W-1:20])) * 38'($signed({1'b0, cfg.inverse}));

	// Mode select and 32-bit saturation
	always_comb begin
		avg_full = (AVG_W'(s3_phi_q) <<< 20) + AVG_W'(s3_plo_q) + AVG_W'(32768);
		case (cfg.mode)
			MODE_WSUM: res = RES_W'(s3_w_q);
			MODE_MAX:  res = RES_W'(s3_max_q);
			MODE_AVG:  res = avg_full[16 +: RES_W];
			default:   res = '0;
		endcase
		if (res > RES_W'(32'sh7FFF_FFFF)) begin
			res_sat = 32'sh7FFF_FFFF;
		end else if (res < -RES_W'(33'sh0_8000_0000)) begin
			res_sat = 32'sh8000_0000;
		end else begin
			res_sat = res[31:0];
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			s3_v_q  <= 1'b0;
			out_v_q <= 1'b0;
			fwd_v_q <= 1'b0;
		end else begin
			if (en) begin
				s1_v_q  <= pop;
				s2_v_q  <= s1_v_q && s1_item_q.last_row;
				s3_v_q  <= s2_v_q;
				out_v_q <= s3_v_q;
			end
			if (ram_we) begin
				fwd_v_q <= 1'b1;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_pos_q   <= s1_item_q.pos;
			fwd_total_q <= new_total;
			fwd_best_q  <= new_best;
		end
		if (en) begin
			s1_item_q     <= item;
			s2_total_q    <= new_total;
			s2_best_q     <= new_best;
			s2_pos_q      <= s1_item_q.pos;
			s2_last_pos_q <= s1_item_q.last_pos;
			s3_w_q        <= wround[TOT_W:14];
			s3_plo_q      <= plo;
			s3_phi_q      <= phi;
			s3_max_q      <= s2_total_q;
			s3_best_q     <= s2_best_q;
			s3_pos_q      <= s2_pos_q;
			s3_last_pos_q <= s2_last_pos_q;
			out_val_q     <= res_sat;
			out_win_q     <= (cfg.mode == MODE_MAX) ? s3_best_q : '0;
			out_pos_q     <= s3_pos_q;
			out_last_q    <= s3_last_pos_q;
		end
	end

	assign out_valid      = out_v_q;
	assign pooled_value   = out_val_q;
	assign winner_index   = out_win_q;
	assign slice_position = out_pos_q;
	assign last_result    = out_last_q;

	assign stat.en       = en;
	assign stat.s1_valid = s1_v_q;

endmodule

// ----- hw/rtl/batch_axis_pool_reducer.sv -----
// Top level of the cross-batch pooling reducer: front end, word queue, back end.
//
// Samples enter on in_valid/in_ready in batch-major order (all positions of
// member 0, then member 1, ...), each word carrying its member's weight.
// Settings are written through cfg_we/cfg_index/cfg_data while the block is
// idle; any write restarts the stream at member 0, position 0.
// One result word leaves on out_valid/out_ready for each sample of the last
// batch member, carrying the pooled value, winner member, position and a
// flag on the final position of the slice.
// Throughput: one word per cycle while the receiver takes results, set by the
// single read-modify-write of the per-position accumulator RAM, with the last
// write forwarded to the next word. A result passes from the queue through the
// RAM read and update, scaling, rounding and saturation to the output register.
// Reset clears the counters, the queue and all valid bits; the settings return
// to max mode, batch 1, slice 1, reciprocal 1.0. The accumulator RAM is not
// cleared: the first member always writes each entry before it is read.
// When the receiver stalls, the back end holds; the 4-word queue keeps taking
// samples until it fills, then in_ready drops.
`timescale 1ns / 1ps
module batch_axis_pool_reducer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bpr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [15:0]             sample_value,
	input  logic signed [15:0]             member_weight,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [31:0]             pooled_value,
	output logic [bpr_pkg::MEM_W-1:0]      winner_index,
	output logic [bpr_pkg::POS_W-1:0]      slice_position,
	output logic                           last_result
);
	import bpr_pkg::*;

	logic              push, q_space, head_valid, take, pop;
	bpr_item_t         fr_item, head_item;
	bpr_cfg_t          cfg;
	bpr_back_stat_t    bk_stat;
	logic [QCNT_W-1:0] q_count;

	assign pop = head_valid && take;

	bpr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_value  (sample_value),
		.member_weight (member_weight),
		.q_space       (q_space),
		.push          (push),
		.item          (fr_item),
		.cfg           (cfg)
	);

	bpr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (fr_item),
		.space      (q_space),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.count      (q_count)
	);

	bpr_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.item_valid     (head_valid),
		.item           (head_item),
		.item_take      (take),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pooled_value   (pooled_value),
		.winner_index   (winner_index),
		.slice_position (slice_position),
		.last_result    (last_result),
		.stat           (bk_stat)
	);

	// Backpressure on the input comes only from a full queue
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (q_count == QCNT_W'(QUEUE_DEPTH)))
		else $error("input stalled while queue has space");

	// A register write restarts the stream
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (fr_item.pos == '0 && fr_item.mem == '0))
		else $error("counters not cleared by register write");

	// Queue level rises on a push without a pop
	a_queue_level: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (q_count == QCNT_W'($past(q_count) + QCNT_W'(1))))
		else $error("queue level did not rise on push");

	// The back end holds only while a result word waits
	a_back_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!bk_stat.en |-> (out_valid && !out_ready))
		else $error("back end stalled without a held result");

endmodule
